// ----- hdl/tpsq_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, widths and helpers for the tree path step query unit.
// No dependencies; imported by the ALU, the top level, the checker and the testbench.
package tpsq_pkg;

    localparam int MAX_NODES   = 1024;
    localparam int ANC_LEVELS  = 11;
    localparam int EDGE_SLOTS  = MAX_NODES - 1;
    localparam int NODE_W      = $clog2(MAX_NODES + 1);
    localparam int ADDR_W      = $clog2(MAX_NODES);
    localparam int DEPTH_W     = $clog2(MAX_NODES);
    localparam int TIME_W      = $clog2(2 * MAX_NODES + 1);
    localparam int CUR_W       = $clog2(EDGE_SLOTS + 1);
    localparam int EDGE_AW     = (EDGE_SLOTS > 1) ? $clog2(EDGE_SLOTS) : 1;
    localparam int STEP_W      = 16;
    localparam int OP_W        = 2;
    localparam int LVL_W       = $clog2(ANC_LEVELS);
    localparam int ALU_W       = (TIME_W > STEP_W) ? TIME_W : STEP_W;

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 2'd0,
        OP_BUILD = 2'd1,
        OP_QUERY = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_ANC
    } alu_op_t;

    typedef struct packed {
        alu_op_t          op;
        logic [ALU_W-1:0] x;
        logic [ALU_W-1:0] y;
        logic [ALU_W-1:0] z;
        logic [ALU_W-1:0] w;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_W-1:0] res;
        logic             flag;
    } alu_rsp_t;

    typedef struct packed {
        logic [NODE_W-1:0] end_a;
        logic [NODE_W-1:0] end_b;
    } edge_word_t;

    typedef struct packed {
        logic [NODE_W-1:0]  node;
        logic [CUR_W-1:0]   cur;
        logic [DEPTH_W-1:0] dep;
    } stack_word_t;

    typedef logic [ANC_LEVELS-1:0][NODE_W-1:0] anc_row_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLR,
        ST_ROOT,
        ST_SCAN,
        ST_EDGE,
        ST_VIS,
        ST_ANC_RD,
        ST_ANC_USE,
        ST_ANC_WR,
        ST_EXIT,
        ST_POP,
        ST_QA,
        ST_QB,
        ST_QT,
        ST_QC1,
        ST_QC2,
        ST_LR,
        ST_LU,
        ST_LT,
        ST_XR,
        ST_XU,
        ST_XD,
        ST_XDW,
        ST_P1,
        ST_P2,
        ST_PS,
        ST_PC,
        ST_PD,
        ST_PE,
        ST_W,
        ST_WU
    } state_t;

    // Map a node number (from one) to its table address.
    function automatic logic [ADDR_W-1:0] node_addr(input logic [NODE_W-1:0] node);
        logic [NODE_W-1:0] idx;
        idx = node - NODE_W'(1);
        return idx[ADDR_W-1:0];
    endfunction

endpackage

// ----- hdl/tpsq_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tpsq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wa,
    input  logic [WIDTH-1:0]                        wd,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] ra,
    output logic [WIDTH-1:0]                        rd
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and register the read word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd <= mem[ra];
    end

endmodule

// ----- hdl/tpsq_alu.sv -----
`timescale 1ns / 1ps
// Shared arithmetic unit: add, subtract with no-borrow flag, ancestor interval test.
// Depends on tpsq_pkg.
module tpsq_alu
    import tpsq_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [ALU_W:0] diff;

    assign diff = {1'b0, req.x} - {1'b0, req.y};

    // Select the operation
    always_comb
    begin
        rsp.res  = '0;
        rsp.flag = 1'b0;
        unique case (req.op)
            ALU_ADD:
            begin
                rsp.res = req.x + req.y;
            end
            ALU_SUB:
            begin
                rsp.res  = diff[ALU_W-1:0];
                rsp.flag = ~diff[ALU_W];
            end
            ALU_ANC:
            begin
                rsp.flag = (req.x <= req.y) && (req.z >= req.w);
            end
            default:
            begin
                rsp.res = '0;
            end
        endcase
    end

endmodule

// ----- hdl/tree_path_step_query_unit.sv -----
`timescale 1ns / 1ps
// Top level of the tree path step query unit: sequencer, tables and shared ALU.
// Depends on tpsq_pkg, tpsq_ram and tpsq_alu.
//
// Usage: a word is taken at a rising edge with start high and busy low.
// operation selects add edge, build tables or path step query; code 3 is
// dropped. An add edge is stored at the accept edge and busy stays low.
// A build raises busy: a clearing sweep over all MAX_NODES (1024) entries
// resets depth, times and ancestor rows, then a depth-first walk with an
// explicit stack in RAM runs: it looks at each edge in turn, builds the
// ancestor row of each node entered by one table read per level and stamps
// the exit time of each node left. A query with a node outside 1..node_count
// (clamped into 1..MAX_NODES) is dropped; otherwise busy stays high through
// the ancestor search over eleven levels and the upward walk, all through
// table reads on one read port per table.
// The answer shows on result_node with result_valid high for exactly one
// cycle as busy falls; the receiver cannot hold it off, so no stall exists.
// Write node_count with cfg_we / cfg_wdata only while idle; not enforced here.
// Reset clears the sequencer, the edge count and sets node_count to one;
// the node tables hold no contents until the first build.
module tree_path_step_query_unit
    import tpsq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [OP_W-1:0]    operation,
    input  logic [NODE_W-1:0]  node_a,
    input  logic [NODE_W-1:0]  node_b,
    input  logic [STEP_W-1:0]  step_count,
    input  logic               cfg_we,
    input  logic [NODE_W-1:0]  cfg_wdata,
    output logic               result_valid,
    output logic [NODE_W-1:0]  result_node
);

    localparam logic [ALU_W-1:0] WALK_TOP = ALU_W'(1) << (ANC_LEVELS - 1);
    localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(ANC_LEVELS - 1);

    // Control registers
    state_t             state_reg, state_next;
    logic [NODE_W-1:0]  node_count_reg;
    logic [CUR_W-1:0]   edge_total_reg, edge_total_next;
    logic [NODE_W-1:0]  sp_reg, sp_next;
    logic [TIME_W-1:0]  clock_reg, clock_next;
    logic               res_valid_reg, res_valid_next;

    // Payload registers
    logic [NODE_W-1:0]  clr_reg, clr_next;
    logic [NODE_W-1:0]  top_node_reg, top_node_next;
    logic [CUR_W-1:0]   top_cur_reg, top_cur_next;
    logic [DEPTH_W-1:0] top_dep_reg, top_dep_next;
    logic [NODE_W-1:0]  other_reg, other_next;
    logic [LVL_W-1:0]   lvl_reg, lvl_next;
    anc_row_t           row_reg, row_next;
    logic [NODE_W-1:0]  anc_node_reg, anc_node_next;
    logic [NODE_W-1:0]  qa_reg, qa_next;
    logic [NODE_W-1:0]  qb_reg, qb_next;
    logic [STEP_W-1:0]  steps_reg, steps_next;
    logic [TIME_W-1:0]  ta_in_reg, ta_in_next, ta_out_reg, ta_out_next;
    logic [TIME_W-1:0]  tb_in_reg, tb_in_next, tb_out_reg, tb_out_next;
    logic [DEPTH_W-1:0] da_reg, da_next, db_reg, db_next, dx_reg, dx_next;
    logic [DEPTH_W-1:0] p1_reg, p1_next, p2_reg, p2_next;
    logic [ALU_W-1:0]   total_reg, total_next;
    logic [NODE_W-1:0]  lift_reg, lift_next, cand_reg, cand_next;
    logic [NODE_W-1:0]  x_reg, x_next;
    logic [NODE_W-1:0]  walk_v_reg, walk_v_next;
    logic [ALU_W-1:0]   walk_s_reg, walk_s_next;
    logic [NODE_W-1:0]  result_reg, result_next;

    // Table ports
    logic               e_we, s_we, d_we, en_we, ex_we, an_we;
    logic [EDGE_AW-1:0] e_wa, e_ra;
    edge_word_t         e_wd, e_rd;
    logic [ADDR_W-1:0]  s_wa, s_ra, d_wa, d_ra, en_wa, en_ra, ex_wa, ex_ra, an_wa, an_ra;
    stack_word_t        s_wd, s_rd;
    logic [DEPTH_W-1:0] d_wd, d_rd;
    logic [TIME_W-1:0]  en_wd, en_rd, ex_wd, ex_rd;
    anc_row_t           an_wd, an_rd;

    alu_req_t           alu_req;
    alu_rsp_t           alu_rsp;

    logic [NODE_W-1:0]  n_live;
    logic [NODE_W-1:0]  edge_other;
    logic               end_a_ok, end_b_ok, qa_ok, qb_ok;

    tpsq_ram #(.WIDTH($bits(edge_word_t)), .DEPTH(EDGE_SLOTS)) u_edge_ram (
        .clk(clk), .we(e_we), .wa(e_wa), .wd(e_wd), .ra(e_ra), .rd(e_rd));
    tpsq_ram #(.WIDTH($bits(stack_word_t)), .DEPTH(MAX_NODES)) u_stack_ram (
        .clk(clk), .we(s_we), .wa(s_wa), .wd(s_wd), .ra(s_ra), .rd(s_rd));
    tpsq_ram #(.WIDTH(DEPTH_W), .DEPTH(MAX_NODES)) u_depth_ram (
        .clk(clk), .we(d_we), .wa(d_wa), .wd(d_wd), .ra(d_ra), .rd(d_rd));
    tpsq_ram #(.WIDTH(TIME_W), .DEPTH(MAX_NODES)) u_entry_ram (
        .clk(clk), .we(en_we), .wa(en_wa), .wd(en_wd), .ra(en_ra), .rd(en_rd));
    tpsq_ram #(.WIDTH(TIME_W), .DEPTH(MAX_NODES)) u_exit_ram (
        .clk(clk), .we(ex_we), .wa(ex_wa), .wd(ex_wd), .ra(ex_ra), .rd(ex_rd));
    tpsq_ram #(.WIDTH($bits(anc_row_t)), .DEPTH(MAX_NODES)) u_anc_ram (
        .clk(clk), .we(an_we), .wa(an_wa), .wd(an_wd), .ra(an_ra), .rd(an_rd));

    tpsq_alu u_alu (
        .req(alu_req),
        .rsp(alu_rsp)
    );

    // Clamp the node count into 1..MAX_NODES
    always_comb
    begin
        if (node_count_reg == '0)
        begin
            n_live = NODE_W'(1);
        end
        else if (node_count_reg > NODE_W'(MAX_NODES))
        begin
            n_live = NODE_W'(MAX_NODES);
        end
        else
        begin
            n_live = node_count_reg;
        end
    end

    assign end_a_ok = (node_a != '0) && (node_a <= NODE_W'(MAX_NODES));
    assign end_b_ok = (node_b != '0) && (node_b <= NODE_W'(MAX_NODES));
    assign qa_ok    = (node_a != '0) && (node_a <= n_live);
    assign qb_ok    = (node_b != '0) && (node_b <= n_live);

    // Pick the far end of the edge word if it touches the top node
    always_comb
    begin
        if (e_rd.end_a == top_node_reg)
        begin
            edge_other = e_rd.end_b;
        end
        else if (e_rd.end_b == top_node_reg)
        begin
            edge_other = e_rd.end_a;
        end
        else
        begin
            edge_other = '0;
        end
    end

    // Sequencer: next state, table accesses and ALU requests
    always_comb
    begin
        state_next      = state_reg;
        edge_total_next = edge_total_reg;
        sp_next         = sp_reg;
        clock_next      = clock_reg;
        res_valid_next  = 1'b0;
        clr_next        = clr_reg;
        top_node_next   = top_node_reg;
        top_cur_next    = top_cur_reg;
        top_dep_next    = top_dep_reg;
        other_next      = other_reg;
        lvl_next        = lvl_reg;
        row_next        = row_reg;
        anc_node_next   = anc_node_reg;
        qa_next         = qa_reg;
        qb_next         = qb_reg;
        steps_next      = steps_reg;
        ta_in_next      = ta_in_reg;
        ta_out_next     = ta_out_reg;
        tb_in_next      = tb_in_reg;
        tb_out_next     = tb_out_reg;
        da_next         = da_reg;
        db_next         = db_reg;
        dx_next         = dx_reg;
        p1_next         = p1_reg;
        p2_next         = p2_reg;
        total_next      = total_reg;
        lift_next       = lift_reg;
        cand_next       = cand_reg;
        x_next          = x_reg;
        walk_v_next     = walk_v_reg;
        walk_s_next     = walk_s_reg;
        result_next     = result_reg;

        e_we  = 1'b0; e_wa  = '0; e_wd  = '0; e_ra  = '0;
        s_we  = 1'b0; s_wa  = '0; s_wd  = '0; s_ra  = '0;
        d_we  = 1'b0; d_wa  = '0; d_wd  = '0; d_ra  = '0;
        en_we = 1'b0; en_wa = '0; en_wd = '0; en_ra = '0;
        ex_we = 1'b0; ex_wa = '0; ex_wd = '0; ex_ra = '0;
        an_we = 1'b0; an_wa = '0; an_wd = '0; an_ra = '0;

        alu_req.op = ALU_ADD;
        alu_req.x  = '0;
        alu_req.y  = '0;
        alu_req.z  = '0;
        alu_req.w  = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (operation)
                        OP_ADD:
                        begin
                            if (end_a_ok && end_b_ok &&
                                (edge_total_reg < CUR_W'(EDGE_SLOTS)))
                            begin
                                e_we            = 1'b1;
                                e_wa            = EDGE_AW'(edge_total_reg);
                                e_wd.end_a      = node_a;
                                e_wd.end_b      = node_b;
                                edge_total_next = edge_total_reg + CUR_W'(1);
                            end
                        end
                        OP_BUILD:
                        begin
                            clr_next   = '0;
                            state_next = ST_CLR;
                        end
                        OP_QUERY:
                        begin
                            if (qa_ok && qb_ok)
                            begin
                                qa_next    = node_a;
                                qb_next    = node_b;
                                steps_next = step_count;
                                state_next = ST_QA;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            // Clear one node's entries a cycle
            ST_CLR:
            begin
                d_we  = 1'b1; d_wa  = clr_reg[ADDR_W-1:0]; d_wd  = '0;
                en_we = 1'b1; en_wa = clr_reg[ADDR_W-1:0]; en_wd = '0;
                ex_we = 1'b1; ex_wa = clr_reg[ADDR_W-1:0]; ex_wd = '0;
                an_we = 1'b1; an_wa = clr_reg[ADDR_W-1:0];
                an_wd = {ANC_LEVELS{clr_reg + NODE_W'(1)}};
                if (clr_reg == NODE_W'(MAX_NODES - 1))
                begin
                    state_next = ST_ROOT;
                end
                else
                begin
                    clr_next = clr_reg + NODE_W'(1);
                end
            end

            // Enter the root; its cleared row already points at itself
            ST_ROOT:
            begin
                en_we         = 1'b1;
                en_wa         = '0;
                en_wd         = TIME_W'(1);
                clock_next    = TIME_W'(1);
                sp_next       = NODE_W'(1);
                top_node_next = NODE_W'(1);
                top_cur_next  = '0;
                top_dep_next  = '0;
                state_next    = ST_SCAN;
            end

            ST_SCAN:
            begin
                if (top_cur_reg < edge_total_reg)
                begin
                    e_ra       = EDGE_AW'(top_cur_reg);
                    state_next = ST_EDGE;
                end
                else
                begin
                    state_next = ST_EXIT;
                end
            end

            ST_EDGE:
            begin
                top_cur_next = top_cur_reg + CUR_W'(1);
                if ((edge_other != '0) && (edge_other <= n_live))
                begin
                    en_ra      = node_addr(edge_other);
                    other_next = edge_other;
                    state_next = ST_VIS;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end

            // Push the parent and enter an unvisited neighbor
            ST_VIS:
            begin
                if (en_rd == '0)
                begin
                    if (sp_reg < NODE_W'(MAX_NODES))
                    begin
                        s_we          = 1'b1;
                        s_wa          = node_addr(sp_reg);
                        s_wd.node     = top_node_reg;
                        s_wd.cur      = top_cur_reg;
                        s_wd.dep      = top_dep_reg;
                        clock_next    = clock_reg + TIME_W'(1);
                        en_we         = 1'b1;
                        en_wa         = node_addr(other_reg);
                        en_wd         = clock_reg + TIME_W'(1);
                        d_we          = 1'b1;
                        d_wa          = node_addr(other_reg);
                        d_wd          = top_dep_reg + DEPTH_W'(1);
                        row_next      = '0;
                        row_next[0]   = top_node_reg;
                        anc_node_next = top_node_reg;
                        lvl_next      = LVL_W'(1);
                        state_next    = ST_ANC_RD;
                    end
                    else
                    begin
                        state_next = ST_EXIT;
                    end
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end

            ST_ANC_RD:
            begin
                an_ra      = node_addr(anc_node_reg);
                state_next = ST_ANC_USE;
            end

            // Level i is level i-1 of the level i-1 ancestor
            ST_ANC_USE:
            begin
                row_next[lvl_reg] = an_rd[lvl_reg - LVL_W'(1)];
                anc_node_next     = an_rd[lvl_reg - LVL_W'(1)];
                if (lvl_reg == LVL_LAST)
                begin
                    state_next = ST_ANC_WR;
                end
                else
                begin
                    lvl_next   = lvl_reg + LVL_W'(1);
                    state_next = ST_ANC_RD;
                end
            end

            ST_ANC_WR:
            begin
                an_we         = 1'b1;
                an_wa         = node_addr(other_reg);
                an_wd         = row_reg;
                sp_next       = sp_reg + NODE_W'(1);
                top_node_next = other_reg;
                top_cur_next  = '0;
                top_dep_next  = top_dep_reg + DEPTH_W'(1);
                state_next    = ST_SCAN;
            end

            // Stamp the exit time and pop
            ST_EXIT:
            begin
                clock_next = clock_reg + TIME_W'(1);
                ex_we      = 1'b1;
                ex_wa      = node_addr(top_node_reg);
                ex_wd      = clock_reg + TIME_W'(1);
                sp_next    = sp_reg - NODE_W'(1);
                if (sp_reg == NODE_W'(1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    s_ra       = node_addr(sp_reg - NODE_W'(1));
                    state_next = ST_POP;
                end
            end

            ST_POP:
            begin
                top_node_next = s_rd.node;
                top_cur_next  = s_rd.cur;
                top_dep_next  = s_rd.dep;
                state_next    = ST_SCAN;
            end

            // Fetch times and depths of both query nodes
            ST_QA:
            begin
                en_ra      = node_addr(qa_reg);
                ex_ra      = node_addr(qa_reg);
                d_ra       = node_addr(qa_reg);
                state_next = ST_QB;
            end

            ST_QB:
            begin
                ta_in_next  = en_rd;
                ta_out_next = ex_rd;
                da_next     = d_rd;
                en_ra       = node_addr(qb_reg);
                ex_ra       = node_addr(qb_reg);
                d_ra        = node_addr(qb_reg);
                state_next  = ST_QT;
            end

            ST_QT:
            begin
                tb_in_next  = en_rd;
                tb_out_next = ex_rd;
                db_next     = d_rd;
                state_next  = ST_QC1;
            end

            ST_QC1:
            begin
                alu_req.op = ALU_ANC;
                alu_req.x  = ALU_W'(ta_in_reg);
                alu_req.y  = ALU_W'(tb_in_reg);
                alu_req.z  = ALU_W'(ta_out_reg);
                alu_req.w  = ALU_W'(tb_out_reg);
                if (alu_rsp.flag)
                begin
                    x_next     = qa_reg;
                    state_next = ST_XD;
                end
                else
                begin
                    state_next = ST_QC2;
                end
            end

            ST_QC2:
            begin
                alu_req.op = ALU_ANC;
                alu_req.x  = ALU_W'(tb_in_reg);
                alu_req.y  = ALU_W'(ta_in_reg);
                alu_req.z  = ALU_W'(tb_out_reg);
                alu_req.w  = ALU_W'(ta_out_reg);
                if (alu_rsp.flag)
                begin
                    x_next     = qb_reg;
                    state_next = ST_XD;
                end
                else
                begin
                    lift_next  = qa_reg;
                    lvl_next   = LVL_LAST;
                    state_next = ST_LR;
                end
            end

            // Lift the start node while it stays below the common ancestor
            ST_LR:
            begin
                an_ra      = node_addr(lift_reg);
                state_next = ST_LU;
            end

            ST_LU:
            begin
                cand_next  = an_rd[lvl_reg];
                en_ra      = node_addr(an_rd[lvl_reg]);
                ex_ra      = node_addr(an_rd[lvl_reg]);
                state_next = ST_LT;
            end

            ST_LT:
            begin
                alu_req.op = ALU_ANC;
                alu_req.x  = ALU_W'(en_rd);
                alu_req.y  = ALU_W'(tb_in_reg);
                alu_req.z  = ALU_W'(ex_rd);
                alu_req.w  = ALU_W'(tb_out_reg);
                if (!alu_rsp.flag)
                begin
                    lift_next = cand_reg;
                end
                if (lvl_reg == '0)
                begin
                    state_next = ST_XR;
                end
                else
                begin
                    lvl_next   = lvl_reg - LVL_W'(1);
                    state_next = ST_LR;
                end
            end

            ST_XR:
            begin
                an_ra      = node_addr(lift_reg);
                state_next = ST_XU;
            end

            ST_XU:
            begin
                x_next     = an_rd[0];
                state_next = ST_XD;
            end

            ST_XD:
            begin
                d_ra       = node_addr(x_reg);
                state_next = ST_XDW;
            end

            ST_XDW:
            begin
                dx_next    = d_rd;
                state_next = ST_P1;
            end

            // Path lengths on each side of the common ancestor
            ST_P1:
            begin
                alu_req.op = ALU_SUB;
                alu_req.x  = ALU_W'(da_reg);
                alu_req.y  = ALU_W'(dx_reg);
                p1_next    = alu_rsp.flag ? alu_rsp.res[DEPTH_W-1:0] : '0;
                state_next = ST_P2;
            end

            ST_P2:
            begin
                alu_req.op = ALU_SUB;
                alu_req.x  = ALU_W'(db_reg);
                alu_req.y  = ALU_W'(dx_reg);
                p2_next    = alu_rsp.flag ? alu_rsp.res[DEPTH_W-1:0] : '0;
                state_next = ST_PS;
            end

            ST_PS:
            begin
                alu_req.op = ALU_ADD;
                alu_req.x  = ALU_W'(p1_reg);
                alu_req.y  = ALU_W'(p2_reg);
                total_next = alu_rsp.res;
                state_next = ST_PC;
            end

            // A count at or past the path length lands on the end node
            ST_PC:
            begin
                alu_req.op = ALU_SUB;
                alu_req.x  = ALU_W'(steps_reg);
                alu_req.y  = total_reg;
                if (alu_rsp.flag)
                begin
                    result_next    = qb_reg;
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    state_next = ST_PD;
                end
            end

            ST_PD:
            begin
                alu_req.op = ALU_SUB;
                alu_req.x  = ALU_W'(steps_reg);
                alu_req.y  = ALU_W'(p1_reg);
                if (alu_rsp.flag && (alu_rsp.res != '0))
                begin
                    state_next = ST_PE;
                end
                else
                begin
                    walk_v_next = qa_reg;
                    walk_s_next = ALU_W'(steps_reg);
                    lvl_next    = '0;
                    state_next  = ST_W;
                end
            end

            // Past the ancestor: climb from the end node by the remainder
            ST_PE:
            begin
                alu_req.op  = ALU_SUB;
                alu_req.x   = total_reg;
                alu_req.y   = ALU_W'(steps_reg);
                walk_s_next = alu_rsp.res;
                walk_v_next = qb_reg;
                lvl_next    = '0;
                state_next  = ST_W;
            end

            // Climb by the top level first, then one bit a level
            ST_W:
            begin
                if (walk_s_reg >= WALK_TOP)
                begin
                    an_ra      = node_addr(walk_v_reg);
                    state_next = ST_WU;
                end
                else if (lvl_reg == LVL_LAST)
                begin
                    result_next    = walk_v_reg;
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else if (walk_s_reg[lvl_reg])
                begin
                    an_ra      = node_addr(walk_v_reg);
                    state_next = ST_WU;
                end
                else
                begin
                    lvl_next = lvl_reg + LVL_W'(1);
                end
            end

            ST_WU:
            begin
                if (walk_s_reg >= WALK_TOP)
                begin
                    walk_v_next = an_rd[ANC_LEVELS-1];
                    walk_s_next = walk_s_reg - WALK_TOP;
                end
                else
                begin
                    walk_v_next = an_rd[lvl_reg];
                    lvl_next    = lvl_reg + LVL_W'(1);
                end
                state_next = ST_W;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            node_count_reg <= NODE_W'(1);
            edge_total_reg <= '0;
            sp_reg         <= '0;
            clock_reg      <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            edge_total_reg <= edge_total_next;
            sp_reg         <= sp_next;
            clock_reg      <= clock_next;
            res_valid_reg  <= res_valid_next;
            if (cfg_we)
            begin
                node_count_reg <= cfg_wdata;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        clr_reg      <= clr_next;
        top_node_reg <= top_node_next;
        top_cur_reg  <= top_cur_next;
        top_dep_reg  <= top_dep_next;
        other_reg    <= other_next;
        lvl_reg      <= lvl_next;
        row_reg      <= row_next;
        anc_node_reg <= anc_node_next;
        qa_reg       <= qa_next;
        qb_reg       <= qb_next;
        steps_reg    <= steps_next;
        ta_in_reg    <= ta_in_next;
        ta_out_reg   <= ta_out_next;
        tb_in_reg    <= tb_in_next;
        tb_out_reg   <= tb_out_next;
        da_reg       <= da_next;
        db_reg       <= db_next;
        dx_reg       <= dx_next;
        p1_reg       <= p1_next;
        p2_reg       <= p2_next;
        total_reg    <= total_next;
        lift_reg     <= lift_next;
        cand_reg     <= cand_next;
        x_reg        <= x_next;
        walk_v_reg   <= walk_v_next;
        walk_s_reg   <= walk_s_next;
        result_reg   <= result_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = res_valid_reg;
    assign result_node  = result_reg;

endmodule

// ----- hdl/tpsq_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the tree path step query unit, bound to the top level.
// Depends on tpsq_pkg and tree_path_step_query_unit.
module tpsq_checker
    import tpsq_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic [OP_W-1:0]   operation,
    input logic [NODE_W-1:0] result_node,
    input logic              result_valid
);

    // A result word lasts one cycle and the next cannot follow at once
    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held longer than one cycle");

    // A result word appears only as the block goes idle
    a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result strobe while busy");

    // An edge add completes at its accept edge
    a_add_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (operation == OP_ADD)) |=> (!busy && !result_valid))
        else $error("edge add raised busy or gave a result");

    // A build always runs its clearing sweep
    a_build_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (operation == OP_BUILD)) |=> busy)
        else $error("build did not raise busy");

    // The answer is always a legal node number
    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((result_node != '0) && (result_node <= NODE_W'(MAX_NODES))))
        else $error("result node out of range");

endmodule

bind tree_path_step_query_unit tpsq_checker u_tpsq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .result_node  (result_node),
    .result_valid (result_valid)
);

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for tree_path_step_query_unit: predicts each query
// answer from a local tree model and checks it. Depends on tpsq_pkg and the RTL.
module tb;
    import tpsq_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [NODE_W-1:0] a;
        logic [NODE_W-1:0] b;
        logic [STEP_W-1:0] steps;
    } word_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [OP_W-1:0]    operation = '0;
    logic [NODE_W-1:0]  node_a = '0;
    logic [NODE_W-1:0]  node_b = '0;
    logic [STEP_W-1:0]  step_count = '0;
    logic               cfg_we = 1'b0;
    logic [NODE_W-1:0]  cfg_wdata = '0;
    logic               result_valid;
    logic [NODE_W-1:0]  result_node;

    word_t             pending_words[$];
    logic [NODE_W-1:0] expected_nodes[$];
    int                mismatch_count = 0;
    int                gap_left = 0;
    bit                no_idle = 0;

    // local copy of the block's state
    int node_limit;
    int edge_total;
    int edge_a[0:EDGE_SLOTS-1];
    int edge_b[0:EDGE_SLOTS-1];
    int depth_of[1:MAX_NODES];
    int t_in[1:MAX_NODES];
    int t_out[1:MAX_NODES];
    int up[1:MAX_NODES][0:ANC_LEVELS-1];
    int stk_node[0:MAX_NODES-1];
    int stk_cur[0:MAX_NODES-1];
    int tick;

    tree_path_step_query_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .node_a       (node_a),
        .node_b       (node_b),
        .step_count   (step_count),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .result_valid (result_valid),
        .result_node  (result_node)
    );

    always #6 clk = ~clk;

    function automatic int live_n();
        if (node_limit < 1) return 1;
        if (node_limit > MAX_NODES) return MAX_NODES;
        return node_limit;
    endfunction

    function automatic bit covers(int u, int v);
        return t_in[u] <= t_in[v] && t_out[u] >= t_out[v];
    endfunction

    function automatic void enter_node(int v, int parent, int dep);
        depth_of[v] = dep;
        tick++;
        t_in[v] = tick;
        up[v][0] = parent;
        for (int i = 1; i < ANC_LEVELS; i++)
            up[v][i] = up[up[v][i-1]][i-1];
    endfunction

    // Reroot at node 1 and redo the depth-first walk over the stored edges.
    function automatic void rebuild_tables();
        int n, sp, v, cur, nxt, oth;
        n = live_n();
        for (int v2 = 1; v2 <= MAX_NODES; v2++)
        begin
            depth_of[v2] = 0;
            t_in[v2] = 0;
            t_out[v2] = 0;
            for (int i = 0; i < ANC_LEVELS; i++) up[v2][i] = v2;
        end
        tick = 0;
        enter_node(1, 1, 0);
        stk_node[0] = 1;
        stk_cur[0] = 0;
        sp = 1;
        while (sp > 0)
        begin
            v = stk_node[sp-1];
            cur = stk_cur[sp-1];
            nxt = 0;
            while (cur < edge_total && nxt == 0)
            begin
                oth = 0;
                if (edge_a[cur] == v) oth = edge_b[cur];
                else if (edge_b[cur] == v) oth = edge_a[cur];
                cur++;
                if (oth != 0 && oth <= n && t_in[oth] == 0) nxt = oth;
            end
            stk_cur[sp-1] = cur;
            if (nxt != 0 && sp < MAX_NODES)
            begin
                enter_node(nxt, v, depth_of[v] + 1);
                stk_node[sp] = nxt;
                stk_cur[sp] = 0;
                sp++;
            end
            else
            begin
                tick++;
                t_out[v] = tick;
                sp--;
            end
        end
    endfunction

    function automatic int common_root(int a, int b);
        int u;
        if (covers(a, b)) return a;
        if (covers(b, a)) return b;
        for (int lvl = ANC_LEVELS - 1; lvl >= 0; lvl--)
        begin
            u = up[a][lvl];
            if (!covers(u, b)) a = u;
        end
        return up[a][0];
    endfunction

    function automatic int climb(int v, int steps);
        int top;
        top = 1 << (ANC_LEVELS - 1);
        while (steps >= top)
        begin
            v = up[v][ANC_LEVELS-1];
            steps -= top;
        end
        for (int i = 0; i < ANC_LEVELS - 1; i++)
            if ((steps >> i) & 1) v = up[v][i];
        return v;
    endfunction

    // Apply one word to the local state; queue the answer of a valid query.
    function automatic void path_step_predict(word_t w);
        int n, x, p1, p2, r, a, b, c;
        a = w.a;
        b = w.b;
        c = w.steps;
        if (w.op == OP_ADD)
        begin
            if (a >= 1 && a <= MAX_NODES && b >= 1 && b <= MAX_NODES
                && edge_total < EDGE_SLOTS)
            begin
                edge_a[edge_total] = a;
                edge_b[edge_total] = b;
                edge_total++;
            end
        end
        else if (w.op == OP_BUILD)
            rebuild_tables();
        else if (w.op == OP_QUERY)
        begin
            n = live_n();
            if (a >= 1 && a <= n && b >= 1 && b <= n)
            begin
                x = common_root(a, b);
                p1 = depth_of[a] > depth_of[x] ? depth_of[a] - depth_of[x] : 0;
                p2 = depth_of[b] > depth_of[x] ? depth_of[b] - depth_of[x] : 0;
                if (c >= p1 + p2) r = b;
                else if (c > p1) r = climb(b, p2 - (c - p1));
                else r = climb(a, c);
                expected_nodes = {expected_nodes, NODE_W'(r)};
            end
        end
    endfunction

    task automatic send(logic [OP_W-1:0] op, int a, int b, int steps);
        word_t w;
        w.op = op;
        w.a = NODE_W'(a);
        w.b = NODE_W'(b);
        w.steps = STEP_W'(steps);
        path_step_predict(w);
        pending_words = {pending_words, w};
    endtask

    // Hold until every word is taken, the block is idle and no answer is owed.
    task automatic drain();
        while (pending_words.size() != 0 || start) @(posedge clk);
        repeat (4) @(posedge clk);
        while (start || busy || expected_nodes.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_nodes(int v);
        drain();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= NODE_W'(v);
        @(posedge clk);
        cfg_we <= 1'b0;
        node_limit = v;
    endtask

    // Drive words from the queue; hold start until the word is taken.
    always @(posedge clk or negedge rst_n)
    begin
        logic go;
        word_t w;
        if (!rst_n)
        begin
            start <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            go = start;
            if (start && !busy) go = 1'b0;
            if (!go)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_words.size() != 0)
                begin
                    w = pending_words.pop_front();
                    operation <= w.op;
                    node_a <= w.a;
                    node_b <= w.b;
                    step_count <= w.steps;
                    go = 1'b1;
                    gap_left = no_idle ? 0 : $urandom_range(0, 9);
                end
            end
            start <= go;
        end
    end

    // Check each answer against the oldest prediction.
    always @(posedge clk)
    begin
        logic [NODE_W-1:0] want;
        if (rst_n && result_valid)
        begin
            if (expected_nodes.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected answer: expected none got %0d", result_node);
            end
            else
            begin
                want = expected_nodes.pop_front();
                if (result_node !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result_node mismatch: expected %0d got %0d",
                                 want, result_node);
                end
            end
        end
    end

    initial
    begin
        #200_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int n, m, k, a, b, c;
        node_limit = 1;
        edge_total = 0;
        rebuild_tables();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: bad endpoints, spare code, small known tree
        set_nodes(8);
        send(OP_ADD, 0, 5, 0);
        send(OP_ADD, 1025, 2, 0);
        send(OP_ADD, 2047, 2047, 65535);
        send(OP_SPARE, 2047, 2047, 65535);
        send(OP_QUERY, 0, 3, 1);
        send(OP_ADD, 1, 2, 0);
        send(OP_ADD, 1, 3, 0);
        send(OP_ADD, 2, 4, 0);
        send(OP_ADD, 2, 5, 0);
        send(OP_ADD, 3, 6, 0);
        send(OP_ADD, 6, 7, 0);
        send(OP_ADD, 7, 8, 0);
        send(OP_ADD, 4, 9, 0);
        send(OP_ADD, 8, 1024, 0);
        send(OP_BUILD, 0, 0, 0);
        send(OP_QUERY, 4, 7, 0);
        send(OP_QUERY, 4, 7, 3);
        send(OP_QUERY, 4, 7, 5);
        send(OP_QUERY, 4, 7, 65535);
        send(OP_QUERY, 7, 4, 2);
        send(OP_QUERY, 1, 8, 2);
        send(OP_QUERY, 5, 5, 1);
        send(OP_QUERY, 3, 9, 1);
        send(OP_QUERY, 8, 1, 2);

        // random phases: new node count, a tree on top of old edges, queries
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph % 5)
                0: n = 0;
                1: n = 2047;
                2: n = 1024;
                default: n = $urandom_range(2, 40);
            endcase
            if (ph == 3) n = 1;
            set_nodes(n);
            no_idle = (ph % 4 == 2);
            n = (n < 1) ? 1 : (n > MAX_NODES ? MAX_NODES : n);
            m = (n > 40) ? $urandom_range(2, 40) : n;
            for (int i = 2; i <= m; i++)
            begin
                if (i > 24 && $urandom_range(0, 1)) continue;
                send(OP_ADD, i, $urandom_range(1, i - 1), $urandom);
            end
            if ($urandom_range(0, 1)) send(OP_ADD, 0, $urandom_range(0, 2047), 0);
            if ($urandom_range(0, 1)) send(OP_SPARE, $urandom, $urandom, $urandom);
            send(OP_BUILD, $urandom, $urandom, $urandom);
            for (int q = 0; q < 15; q++)
            begin
                k = $urandom_range(0, 19);
                a = (k == 0) ? $urandom_range(0, 2047) :
                    (k < 4 ? $urandom_range(1, n) : $urandom_range(1, m));
                b = (k == 1) ? $urandom_range(0, 2047) :
                    (k < 6 ? $urandom_range(1, n) : $urandom_range(1, m));
                case ($urandom_range(0, 5))
                    0: c = 0;
                    1: c = 65535;
                    2: c = $urandom;
                    default: c = $urandom_range(0, 12);
                endcase
                send(OP_QUERY, a, b, c);
            end
        end

        // fill the edge store to its end, then query the widest tree
        set_nodes(1024);
        no_idle = 0;
        while (edge_total < EDGE_SLOTS)
        begin
            send(OP_ADD, $urandom_range(1000, 1024), $urandom_range(1000, 1024), 0);
            if (pending_words.size() > 64) drain();
        end
        // store is full: drop these adds
        for (int i = 0; i < 4; i++) send(OP_ADD, 1, 1023, 0);
        send(OP_ADD, 5, 6, 0);
        send(OP_BUILD, 0, 0, 0);
        for (int q = 0; q < 30; q++)
        begin
            a = $urandom_range(0, 1) ? $urandom_range(1, 1024) : $urandom_range(1, 40);
            b = $urandom_range(0, 1) ? $urandom_range(1, 1024) : $urandom_range(1, 40);
            send(OP_QUERY, a, b, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 10));
        end

        drain();
        repeat (100) @(posedge clk);
        if (mismatch_count == 0 && expected_nodes.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
